@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the controller and datapath rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/scrd_pkg.sv @@
// shared types and constants for the sparse row dot-product block
`default_nettype none

package scrd_pkg;

    localparam int unsigned MODE_W  = 2;
    localparam int unsigned INDEX_W = 16;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned SUM_W   = 64;

    localparam logic [MODE_W-1:0] MODE_XLOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROW   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NZ    = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic x_write;
        logic row_load;
        logic x_read;
        logic mul;
        logic acc;
        logic emit;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              last;
    } t_dp_status;

endpackage

`default_nettype wire

@@ hw/rtl/scrd_ctrl.sv @@
// controller state machine sequencing one word through the datapath
`default_nettype none
`include "assert_macros.svh"

module scrd_ctrl
    import scrd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_ACC  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_status.mode)
                    MODE_XLOAD: begin
                        o_cmd.x_write = 1'b1;
                    end
                    MODE_ROW: begin
                        o_cmd.row_load = 1'b1;
                        o_cmd.emit     = i_status.last;
                    end
                    MODE_NZ: begin
                        o_cmd.x_read = 1'b1;
                        n_state      = S_MUL;
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc  = 1'b1;
                o_cmd.emit = i_status.last;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    // checks
    `ASSERT_NEXT(a_accept_to_exec, i_clk, i_rst_n, start && !busy, r_state == S_EXEC)
    `ASSERT_IMPLY(a_acc_after_mul, i_clk, i_rst_n, r_state == S_ACC, $past(r_state) == S_MUL)
    `ASSERT_IMPLY(a_one_action, i_clk, i_rst_n, 1'b1,
        $onehot0({o_cmd.x_write, o_cmd.row_load, o_cmd.x_read, o_cmd.mul, o_cmd.acc}))

endmodule

`default_nettype wire

@@ hw/rtl/scrd_datapath.sv @@
// datapath: x vector memory, multiplier, 64-bit accumulator and result register
`default_nettype none
`include "assert_macros.svh"

module scrd_datapath
    import scrd_pkg::*;
#(
    parameter int unsigned X_DEPTH = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_dp_cmd                   i_cmd,
    output t_dp_status                     o_status,
    input  wire logic [MODE_W-1:0]         i_mode,
    input  wire logic [INDEX_W-1:0]        i_index,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                      i_last_in_row,
    output logic                           o_valid,
    output logic [INDEX_W-1:0]             o_row_number,
    output logic signed [SUM_W-1:0]        o_row_sum,
    output logic                           o_overflowed
);

    localparam int unsigned AW = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
    localparam logic [INDEX_W:0] X_LIMIT = (INDEX_W+1)'(X_DEPTH);

    // captured word
    logic [MODE_W-1:0]         r_mode;
    logic [INDEX_W-1:0]        r_index;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_last;

    logic signed [VALUE_W-1:0] mem [X_DEPTH];
    logic signed [VALUE_W-1:0] r_xdata;
    logic                      r_col_ok;
    logic signed [SUM_W-1:0]   r_prod;

    logic signed [SUM_W-1:0]   r_acc;
    logic [INDEX_W-1:0]        r_cur_row;
    logic                      r_wrapped;

    logic                      r_valid;
    logic [INDEX_W-1:0]        r_out_row;
    logic signed [SUM_W-1:0]   r_out_sum;
    logic                      r_out_ovf;

    logic                      in_range;
    logic signed [VALUE_W-1:0] x_op;
    logic signed [SUM_W-1:0]   n_sum;
    logic                      add_ovf;
    logic signed [SUM_W-1:0]   init_sum;

    assign in_range = ({1'b0, r_index} < X_LIMIT);
    assign x_op     = r_col_ok ? r_xdata : '0;
    assign n_sum    = r_acc + r_prod;
    assign add_ovf  = (r_acc[SUM_W-1] == r_prod[SUM_W-1]) &&
                      (n_sum[SUM_W-1] != r_acc[SUM_W-1]);
    assign init_sum = SUM_W'(r_value);

    assign o_status.mode = r_mode;
    assign o_status.last = r_last;

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_index <= i_index;
            r_value <= i_value;
            r_last  <= i_last_in_row;
        end
    end

    // x memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.x_write && in_range) begin
            mem[r_index[AW-1:0]] <= r_value;
        end
    end

    // x memory read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.x_read) begin
            r_xdata  <= mem[r_index[AW-1:0]];
            r_col_ok <= in_range;
        end
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= r_value * x_op;
        end
    end

    // row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_cur_row <= '0;
            r_wrapped <= 1'b0;
        end else if (i_cmd.row_load) begin
            r_acc     <= init_sum;
            r_cur_row <= r_index;
            r_wrapped <= 1'b0;
        end else if (i_cmd.acc) begin
            r_acc     <= n_sum;
            r_wrapped <= r_wrapped | add_ovf;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (i_cmd.row_load) begin
                r_out_row <= r_index;
                r_out_sum <= init_sum;
                r_out_ovf <= 1'b0;
            end else begin
                r_out_row <= r_cur_row;
                r_out_sum <= n_sum;
                r_out_ovf <= r_wrapped | add_ovf;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_row_number = r_out_row;
    assign o_row_sum    = r_out_sum;
    assign o_overflowed = r_out_ovf;

    // checks
    `ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, r_valid, !r_valid)
    `ASSERT_IMPLY(a_emit_source, i_clk, i_rst_n, i_cmd.emit, i_cmd.row_load || i_cmd.acc)
    `ASSERT_NEXT(a_empty_row_clean, i_clk, i_rst_n, i_cmd.emit && i_cmd.row_load,
        !r_out_ovf && !r_wrapped)

endmodule

`default_nettype wire

@@ hw/rtl/sparse_csr_row_dot_top.sv @@
// top level of the csr sparse row dot-product block
//
// Usage: a word (mode, index, value, last_in_row) is taken at a rising edge
// where start is high and busy is low. Mode 0 writes value into x[index],
// mode 1 starts row index with value as its initial sum, mode 2 adds
// value * x[index] to the running row sum. Mode 3 is ignored.
// A finished row (mode 1 with last set, or mode 2 with last set) is shown
// on o_row_number / o_row_sum / o_overflowed for exactly one cycle with
// o_valid high; the receiver cannot stall it.
// Sequencing: mode 0, 1 and 3 words keep busy high for the execute state;
// mode 2 words keep it high for execute (x memory read), multiply and
// accumulate, so no new word is taken until the last one is through.
// o_valid is registered from the emit command, raised in the execute state
// for a row start and in the accumulate state for the last nonzero of a row.
// Reset (i_rst_n low, synchronous) clears the controller, the accumulator,
// the current row and the overflow flag. The x memory is not cleared: an
// entry must be written before any nonzero reads it.
`default_nettype none

module sparse_csr_row_dot_top
    import scrd_pkg::*;
#(
    parameter int unsigned X_DEPTH = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [MODE_W-1:0]         i_mode,
    input  wire logic [INDEX_W-1:0]        i_index,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                      i_last_in_row,
    output logic                           o_valid,
    output logic [INDEX_W-1:0]             o_row_number,
    output logic signed [SUM_W-1:0]        o_row_sum,
    output logic                           o_overflowed
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencing
    scrd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // storage and arithmetic
    scrd_datapath #(
        .X_DEPTH (X_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_mode        (i_mode),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_last_in_row (i_last_in_row),
        .o_valid       (o_valid),
        .o_row_number  (o_row_number),
        .o_row_sum     (o_row_sum),
        .o_overflowed  (o_overflowed)
    );

endmodule

`default_nettype wire
